@@ rtl/core/ackrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ackrt_pkg: shared types and constants of the acknowledgement retry table
// Result kinds, register indexes, reset values and stream widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ackrt_pkg;

  localparam int unsigned DefaultSlots = 8;
  localparam int unsigned MaxReported  = 8;

  localparam logic [3:0]  NormalLimitRst    = 4'd3;
  localparam logic [3:0]  CriticalLimitRst  = 4'd8;
  localparam logic [15:0] NormalBaseRst     = 16'd2000;
  localparam logic [15:0] CriticalBaseRst   = 16'd3000;

  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_REMOVED   = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_RETRY     = 3'd4,
    KIND_EXPIRED   = 3'd5,
    KIND_TICK_DONE = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    REG_NORMAL_LIMIT   = 2'd0,
    REG_CRITICAL_LIMIT = 2'd1,
    REG_NORMAL_BASE    = 2'd2,
    REG_CRITICAL_BASE  = 2'd3
  } reg_e;

  localparam logic [1:0] TierNormal   = 2'd1;
  localparam logic [1:0] TierCritical = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/ack_retry_table_backoff_top.sv @@
// An add or a remove scans the slots in order, one slot per cycle while the output register is free.
// A tick walks every slot in order; each due slot either expires or gets a new deadline,
// and the jitter modulo runs on one shared restoring divider, one bit per cycle, 32 bits.
// One item is in work at a time, and a word stalled at the output holds
// the sequencer until it is taken. Reset (rst_ni low, asynchronous) clears the slot valid
// bits, the sequencer and the output valid bit, and loads the configuration defaults.
// ----------------------------------------------------------------------------
// ack_retry_table_backoff_top: retransmission table with exponential backoff
// A slot table walked by a small sequencer, with one shared serial remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_retry_table_backoff_top
  import ackrt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = DefaultSlots
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write channel.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  // Input stream. tuser holds the mode. tdata from bit 0: id(32), dest(32),
  // tier(2), now_ms(32), random_word(32), six zero pad bits.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  input  wire logic [1:0]           s_axis_tuser,
  // Output stream. tuser holds the result kind. tdata from bit 0: slot(3), id(32),
  // dest(32), attempt_count(4), one zero pad bit. tlast is last.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,
  output logic [2:0]                m_axis_tuser,
  output logic                      m_axis_tlast
);

  localparam int unsigned SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned EvW   = $clog2(MaxReported + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_TICK_RD, ST_TICK_CALC, ST_DIV, ST_TICK_WR,
    ST_EMIT, ST_DONE
  } state_e;

  // Configuration is taken whenever offered.
  logic [3:0]  norm_lim_q, crit_lim_q;
  logic [15:0] norm_base_q, crit_base_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_lim_q  <= NormalLimitRst;
      crit_lim_q  <= CriticalLimitRst;
      norm_base_q <= NormalBaseRst;
      crit_base_q <= CriticalBaseRst;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_NORMAL_LIMIT:   norm_lim_q  <= cfg_data_i[3:0];
        REG_CRITICAL_LIMIT: crit_lim_q  <= cfg_data_i[3:0];
        REG_NORMAL_BASE:    norm_base_q <= cfg_data_i;
        REG_CRITICAL_BASE:  crit_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Slot table. Only the valid bits are reset.
  logic [TABLE_SLOTS-1:0] act_q;
  logic [31:0] id_q   [TABLE_SLOTS];
  logic [31:0] dest_q [TABLE_SLOTS];
  logic [1:0]  tier_q [TABLE_SLOTS];
  logic [3:0]  att_q  [TABLE_SLOTS];
  logic [3:0]  lim_q  [TABLE_SLOTS];
  logic [31:0] dl_q   [TABLE_SLOTS];

  // Latched input word.
  mode_e       mode_q;
  logic [31:0] in_id_q, in_dest_q, now_q, rnd_q;
  logic [1:0]  in_tier_q;

  state_e          state_q;
  logic [CntW-1:0] idx_q;
  logic [EvW-1:0]  nev_q;

  // Working registers for the current tick slot.
  logic [3:0]  w_att_q;
  logic [31:0] delay_q, q_q;
  logic [32:0] mod_q;     // divisor 2q+1
  logic [32:0] rem_q;
  logic [31:0] dvd_q;
  logic [5:0]  bit_q;
  logic        expire_q;

  logic [OutDataW-1:0] o_data_q;
  kind_e               o_kind_q;
  logic                o_last_q, o_valid_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

  logic [SlotW-1:0] idx;
  assign idx = idx_q[SlotW-1:0];

  function automatic logic [OutDataW-1:0] pack(logic [2:0] s, logic [31:0] i,
                                                 logic [31:0] d, logic [3:0] a);
    pack = {1'b0, a, d, i, s};
  endfunction

  logic [15:0] base_cur;
  always_comb begin
    case (tier_q[idx])
      TierNormal:   base_cur = norm_base_q;
      TierCritical: base_cur = crit_base_q;
      default:      base_cur = 16'd0;
    endcase
  end

  logic [32:0] rem_sh;
  assign rem_sh = {rem_q[31:0], dvd_q[31]};

  // The output register is free when empty or when its word leaves this cycle.
  // The sequencer loads a new word only then.
  logic out_free, out_load;
  assign out_free = !o_valid_q || m_axis_tready;

  always_comb begin
    case (state_q)
      ST_SCAN: out_load = out_free && ((idx_q == CntW'(TABLE_SLOTS)) ||
                          (mode_q == MODE_ADD && !act_q[idx]) ||
                          (mode_q == MODE_REMOVE && act_q[idx] && id_q[idx] == in_id_q));
      ST_EMIT, ST_DONE: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (out_load) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= '0;
      idx_q     <= '0;
      nev_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q    <= mode_e'(s_axis_tuser);
            in_id_q   <= s_axis_tdata[31:0];
            in_dest_q <= s_axis_tdata[63:32];
            in_tier_q <= s_axis_tdata[65:64];
            now_q     <= s_axis_tdata[97:66];
            rnd_q     <= s_axis_tdata[129:98];
            idx_q     <= '0;
            nev_q     <= '0;
            state_q   <= (s_axis_tuser == MODE_NONE) ? ST_IDLE :
                         (s_axis_tuser == MODE_TICK) ? ST_TICK_RD : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            if (idx_q == CntW'(TABLE_SLOTS)) begin
              o_last_q  <= 1'b1;
              o_kind_q  <= (mode_q == MODE_ADD) ? KIND_FULL : KIND_NOT_FOUND;
              o_data_q  <= (mode_q == MODE_ADD) ?
                pack(3'd0, in_id_q, in_dest_q, 4'd0) :
                pack(3'd0, in_id_q, 32'd0, 4'd0);
              state_q   <= ST_IDLE;
            end else if (mode_q == MODE_ADD && !act_q[idx]) begin
              act_q[idx]  <= 1'b1;
              id_q[idx]   <= in_id_q;
              dest_q[idx] <= in_dest_q;
              tier_q[idx] <= in_tier_q;
              att_q[idx]  <= 4'd0;
              lim_q[idx]  <= (in_tier_q == TierNormal) ? norm_lim_q :
                             (in_tier_q == TierCritical) ? crit_lim_q : 4'd0;
              dl_q[idx]   <= now_q + ((in_tier_q == TierNormal) ? 32'(norm_base_q) :
                             (in_tier_q == TierCritical) ? 32'(crit_base_q) : 32'd0);
              o_last_q  <= 1'b1;
              o_kind_q  <= KIND_ADDED;
              o_data_q  <= pack(3'(idx_q), in_id_q, in_dest_q, 4'd0);
              state_q   <= ST_IDLE;
            end else if (mode_q == MODE_REMOVE && act_q[idx] && id_q[idx] == in_id_q) begin
              act_q[idx] <= 1'b0;
              o_last_q   <= 1'b1;
              o_kind_q   <= KIND_REMOVED;
              o_data_q   <= pack(3'(idx_q), id_q[idx], dest_q[idx], att_q[idx]);
              state_q    <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_TICK_RD: begin
          if (idx_q == CntW'(TABLE_SLOTS)) begin
            state_q <= ST_DONE;
          end else if (act_q[idx] && now_q >= dl_q[idx]) begin
            w_att_q  <= att_q[idx] + 4'd1;
            expire_q <= (att_q[idx] + 4'd1) >= lim_q[idx];
            delay_q  <= 32'(base_cur) << (att_q[idx] + 4'd1);
            state_q  <= ST_TICK_CALC;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_TICK_CALC: begin
          q_q   <= {2'b00, delay_q[31:2]};
          mod_q <= {2'b00, delay_q[31:2], 1'b1};
          rem_q <= '0;
          dvd_q <= rnd_q;
          bit_q <= 6'd32;
          state_q <= (expire_q || delay_q[31:2] == 30'd0) ? ST_TICK_WR : ST_DIV;
        end
        ST_DIV: begin
          rem_q <= (rem_sh >= mod_q) ? rem_sh - mod_q : rem_sh;
          dvd_q <= {dvd_q[30:0], 1'b0};
          bit_q <= bit_q - 6'd1;
          if (bit_q == 6'd1) state_q <= ST_TICK_WR;
        end
        ST_TICK_WR: begin
          att_q[idx] <= w_att_q;
          if (expire_q) act_q[idx] <= 1'b0;
          else if (q_q == 32'd0) dl_q[idx] <= now_q + delay_q;
          else dl_q[idx] <= now_q + delay_q - q_q + rem_q[31:0];
          state_q <= (nev_q < EvW'(MaxReported)) ? ST_EMIT : ST_TICK_RD;
          if (nev_q >= EvW'(MaxReported)) idx_q <= idx_q + 1'b1;
        end
        ST_EMIT: begin
          if (out_free) begin
            o_last_q  <= 1'b0;
            o_kind_q  <= expire_q ? KIND_EXPIRED : KIND_RETRY;
            o_data_q  <= pack(3'(idx_q), id_q[idx], dest_q[idx], w_att_q);
            nev_q     <= nev_q + 1'b1;
            idx_q     <= idx_q + 1'b1;
            state_q   <= ST_TICK_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            o_last_q  <= 1'b1;
            o_kind_q  <= KIND_TICK_DONE;
            o_data_q  <= pack(3'd0, 32'd0, 32'd0, 4'd0);
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TICK_WR && !expire_q && q_q != 32'd0 |-> rem_q < mod_q)
    else $error("jitter remainder out of range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !s_axis_tready)
    else $error("ready while dividing");
`endif

endmodule

`default_nettype wire
